// ===== sv/two_level_slot_pool_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Slot pool allocator assertion macros
// Shorthand for clocked implication checks used by the checker.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_SLOT_POOL_ALLOCATOR_MACROS_SVH
`define TWO_LEVEL_SLOT_POOL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define SPA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slot pool check failed");

// Next-cycle implication, sampled on clk and disabled in reset.
`define SPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slot pool check failed");

`endif

// ===== sv/spa_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot pool allocator package
// Sizes, pointer encoding, controller commands and status shared by the block.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int MAX_GROUPS      = 16;
  localparam int SLOTS_PER_GROUP = 16;
  localparam int GW              = $clog2(MAX_GROUPS);
  localparam int SW              = $clog2(SLOTS_PER_GROUP);
  localparam int AW              = GW + SW;
  localparam int CFG_W           = 5;

  // Pointers carry one extra bit; a set top bit is the null pointer.
  localparam logic [GW:0] GNIL = {1'b1, {GW{1'b0}}};
  localparam logic [SW:0] SNIL = {1'b1, {SW{1'b0}}};
  localparam logic [SW:0] FULL = (SW+1)'(SLOTS_PER_GROUP);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DISPATCH, ST_NEW, ST_ARD, ST_AWR, ST_FREE, ST_FAIL, ST_OUT
  } spa_state_t;

  typedef enum logic [2:0] {
    CMD_NONE, CMD_LATCH, CMD_NEW, CMD_ARD, CMD_AWR, CMD_FREE, CMD_FAIL, CMD_OUT
  } spa_cmd_t;

  typedef struct packed {
    logic is_free;
    logic list_empty;
    logic spare_empty;
    logic out_busy;
  } spa_status_t;

endpackage

// ===== sv/two_level_slot_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// Two-level slot pool allocator
// Hands out and takes back (group, slot) handles from group free lists.
// ----------------------------------------------------------------------------
// One request is taken at a time. A free steps through dispatch, free and output
// states to the next ready, an allocation through dispatch, read, write and
// output, and one that must open a spare group adds a new-group state first.
// The result word sits in an output register, so a new request is accepted
// while it waits. The register write sets the slot count of groups opened
// after it.
module two_level_slot_pool_allocator import spa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             req_type,
  input  logic [GW-1:0]    free_group,
  input  logic [SW-1:0]    free_slot,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             status,
  output logic [GW-1:0]    alloc_group,
  output logic [SW-1:0]    alloc_slot,
  output logic [GW:0]      groups_active
);

  spa_cmd_t    cmd;
  spa_status_t stat;

  assign cfg_ready = 1'b1;

  spa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spa_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .free_group    (free_group),
    .free_slot     (free_slot),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .alloc_group   (alloc_group),
    .alloc_slot    (alloc_slot),
    .groups_active (groups_active)
  );

endmodule

// ===== sv/spa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/spa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Slot pool allocator controller
// Steps one request through the datapath and hands the word to the output.
// ----------------------------------------------------------------------------
module spa_ctrl import spa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  spa_status_t stat,
  output spa_cmd_t    cmd
);

  spa_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        if (stat.is_free) state_next = ST_FREE;
        else if (!stat.list_empty) state_next = ST_ARD;
        else if (!stat.spare_empty) state_next = ST_NEW;
        else state_next = ST_FAIL;
      end
      ST_NEW:      state_next = ST_ARD;
      ST_ARD:      state_next = ST_AWR;
      ST_AWR:      state_next = ST_OUT;
      ST_FREE:     state_next = ST_OUT;
      ST_FAIL:     state_next = ST_OUT;
      ST_OUT:      if (!stat.out_busy) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = CMD_NONE;
    unique case (state)
      ST_IDLE:     if (in_valid) cmd = CMD_LATCH;
      ST_DISPATCH: cmd = CMD_NONE;
      ST_NEW:      cmd = CMD_NEW;
      ST_ARD:      cmd = CMD_ARD;
      ST_AWR:      cmd = CMD_AWR;
      ST_FREE:     cmd = CMD_FREE;
      ST_FAIL:     cmd = CMD_FAIL;
      ST_OUT:      if (!stat.out_busy) cmd = CMD_OUT;
      default:     cmd = CMD_NONE;
    endcase
  end

  assign in_ready = (state == ST_IDLE);

endmodule

// ===== sv/spa_dp.sv =====
// ----------------------------------------------------------------------------
// Slot pool allocator datapath
// Group tables, list pointers, slot link memory and the result register.
// ----------------------------------------------------------------------------
module spa_dp import spa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  spa_cmd_t          cmd,
  output spa_status_t       stat,
  input  logic              cfg_valid,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              req_type,
  input  logic [GW-1:0]     free_group,
  input  logic [SW-1:0]     free_slot,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              status,
  output logic [GW-1:0]     alloc_group,
  output logic [SW-1:0]     alloc_slot,
  output logic [GW:0]       groups_active
);

  logic [CFG_W-1:0]           slots_cfg;
  logic [SLOTS_PER_GROUP-1:0] link_ok [MAX_GROUPS];
  logic [SLOTS_PER_GROUP-1:0] used    [MAX_GROUPS];
  logic [SW:0]                gtop    [MAX_GROUPS];
  logic [SW:0]                gcount  [MAX_GROUPS];
  logic [SW:0]                gsize   [MAX_GROUPS];
  logic [GW:0]                gnext   [MAX_GROUPS];
  logic [GW:0]                gprev   [MAX_GROUPS];
  logic [MAX_GROUPS-1:0]      glisted;
  logic [GW:0]                head, tail, spare, active;
  logic                       rtype;
  logic [GW-1:0]              rg, ag, res_g;
  logic [SW-1:0]              rs, as, res_s;
  logic                       res_status;

  logic [SW:0]   eff_size, rdata, dflt, nxt, fsz, fcnt1;
  logic [GW-1:0] hg, sg, ug, apg;
  logic [SW:0]   ht;
  logic          fvalid, frel, do_unlink, do_app, ram_we;
  logic [GW:0]   up, un;

  always_comb begin
    if (slots_cfg == '0) eff_size = (SW+1)'(1);
    else if ({1'b0, slots_cfg} > {{(CFG_W+1-(SW+1)){1'b0}}, FULL}) eff_size = FULL;
    else eff_size = slots_cfg[SW:0];
  end

  assign hg = head[GW-1:0];
  assign ht = gtop[hg];
  assign sg = spare[GW-1:0];

  // A slot whose link was never written since setup follows the initial chain.
  always_comb begin
    dflt = ({1'b0, as} + (SW+1)'(1) < gsize[ag]) ? ({1'b0, as} + (SW+1)'(1)) : SNIL;
    nxt  = link_ok[ag][as] ? rdata : dflt;
  end

  always_comb begin
    fsz    = gsize[rg];
    fcnt1  = gcount[rg] + (SW+1)'(1);
    fvalid = (fsz != '0) && ({1'b0, rs} < fsz) && used[rg][rs];
    frel   = fvalid && (fcnt1 >= fsz);
  end

  always_comb begin
    do_unlink = 1'b0;
    ug        = rg;
    do_app    = 1'b0;
    apg       = rg;
    if (cmd == CMD_AWR) begin
      do_unlink = (gcount[ag] == (SW+1)'(1));
      ug        = ag;
    end else if (cmd == CMD_FREE) begin
      do_unlink = frel && glisted[rg];
      do_app    = fvalid && !frel && !glisted[rg];
    end else if (cmd == CMD_NEW) begin
      do_app = 1'b1;
      apg    = sg;
    end
    up = gprev[ug];
    un = gnext[ug];
  end

  assign ram_we = (cmd == CMD_FREE) && fvalid;

  spa_ram #(.WIDTH(SW+1), .DEPTH(MAX_GROUPS*SLOTS_PER_GROUP)) u_link (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({rg, rs}),
    .wdata (gtop[rg]),
    .raddr ({hg, ht[SW-1:0]}),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_cfg <= CFG_W'(SLOTS_PER_GROUP);
      for (int g = 0; g < MAX_GROUPS; g++) begin
        link_ok[g] <= '0;
        used[g]    <= '0;
        gtop[g]    <= SNIL;
        gcount[g]  <= '0;
        gsize[g]   <= '0;
        gprev[g]   <= GNIL;
        gnext[g]   <= (g + 1 < MAX_GROUPS) ? (GW+1)'(g + 1) : GNIL;
      end
      gtop[0]   <= '0;
      gcount[0] <= FULL;
      gsize[0]  <= FULL;
      gnext[0]  <= GNIL;
      glisted   <= MAX_GROUPS'(1);
      head      <= '0;
      tail      <= '0;
      spare     <= (GW+1)'(1);
      active    <= (GW+1)'(1);
    end else begin
      if (cfg_valid) slots_cfg <= cfg_data;
      case (cmd)
        CMD_LATCH: begin
          rtype <= req_type;
          rg    <= free_group;
          rs    <= free_slot;
        end
        CMD_NEW: begin
          spare       <= gnext[sg];
          link_ok[sg] <= '0;
          used[sg]    <= '0;
          gtop[sg]    <= '0;
          gcount[sg]  <= eff_size;
          gsize[sg]   <= eff_size;
          active      <= active + (GW+1)'(1);
        end
        CMD_ARD: begin
          ag <= hg;
          as <= ht[SW-1:0];
        end
        CMD_AWR: begin
          gtop[ag]     <= nxt;
          used[ag][as] <= 1'b1;
          gcount[ag]   <= gcount[ag] - (SW+1)'(1);
          res_status   <= 1'b0;
          res_g        <= ag;
          res_s        <= as;
        end
        CMD_FREE: begin
          if (fvalid) begin
            used[rg][rs]    <= 1'b0;
            link_ok[rg][rs] <= 1'b1;
            gtop[rg]        <= {1'b0, rs};
            gcount[rg]      <= fcnt1;
            if (frel) begin
              gtop[rg]   <= SNIL;
              gcount[rg] <= '0;
              gsize[rg]  <= '0;
              active     <= active - (GW+1)'(1);
            end
          end
          res_status <= 1'b0;
          res_g      <= '0;
          res_s      <= '0;
        end
        CMD_FAIL: begin
          res_status <= 1'b1;
          res_g      <= '0;
          res_s      <= '0;
        end
        default: begin
        end
      endcase
      if (do_unlink) begin
        if (up[GW]) head <= un; else gnext[up[GW-1:0]] <= un;
        if (un[GW]) tail <= up; else gprev[un[GW-1:0]] <= up;
        gprev[ug]   <= GNIL;
        gnext[ug]   <= GNIL;
        glisted[ug] <= 1'b0;
      end
      if (do_app) begin
        gprev[apg] <= tail;
        gnext[apg] <= GNIL;
        if (tail[GW]) head <= {1'b0, apg}; else gnext[tail[GW-1:0]] <= {1'b0, apg};
        tail         <= {1'b0, apg};
        glisted[apg] <= 1'b1;
      end
      // A released group goes back on top of the spare stack.
      if ((cmd == CMD_FREE) && frel) begin
        gnext[rg] <= spare;
        spare     <= {1'b0, rg};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == CMD_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_OUT) begin
      status        <= res_status;
      alloc_group   <= res_g;
      alloc_slot    <= res_s;
      groups_active <= active;
    end
  end

  assign stat.is_free     = rtype;
  assign stat.list_empty  = head[GW];
  assign stat.spare_empty = spare[GW];
  assign stat.out_busy    = out_valid && !out_ready;

endmodule

// ===== sv/spa_checker.sv =====
// ----------------------------------------------------------------------------
// Slot pool allocator checker
// Port-level checks on the result word and request sequencing.
// ----------------------------------------------------------------------------
`include "two_level_slot_pool_allocator_macros.svh"

module spa_checker import spa_pkg::*; (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic          status,
  input logic [GW-1:0] alloc_group,
  input logic [SW-1:0] alloc_slot,
  input logic [GW:0]   groups_active
);

  `SPA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SPA_ASSERT_NOW(a_fail_zero, out_valid && status, alloc_group == '0 && alloc_slot == '0)
  `SPA_ASSERT_NOW(a_active_max, out_valid, groups_active <= (GW+1)'(MAX_GROUPS))
  `SPA_ASSERT_NEXT(a_one_at_time, in_valid && in_ready, !in_ready)

endmodule

bind two_level_slot_pool_allocator spa_checker u_spa_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .alloc_group   (alloc_group),
  .alloc_slot    (alloc_slot),
  .groups_active (groups_active)
);

// ===== dv/two_level_slot_pool_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// Slot pool allocator testbench
// Drives allocate and free requests through the valid/ready request channel,
// predicts every result word with a behavioral copy of the group lists and
// checks each result field by field, across several slot count settings and
// idling phases.
// ----------------------------------------------------------------------------
module two_level_slot_pool_allocator_tb;
  import spa_pkg::*;

  localparam int NG = MAX_GROUPS;
  localparam int NS = SLOTS_PER_GROUP;
  localparam int NIL = -1;
  localparam int REQ_ALLOC = 0;
  localparam int REQ_FREE = 1;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic          kind;
    logic [GW-1:0] grp;
    logic [SW-1:0] slt;
  } request_t;

  typedef struct packed {
    logic          failed;
    logic [GW-1:0] grp;
    logic [SW-1:0] slt;
    logic [GW:0]   active;
  } grant_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic req_type = 0;
  logic [GW-1:0] free_group = '0;
  logic [SW-1:0] free_slot = '0;
  logic out_valid;
  logic out_ready = 0;
  logic status;
  logic [GW-1:0] alloc_group;
  logic [SW-1:0] alloc_slot;
  logic [GW:0] groups_active;

  two_level_slot_pool_allocator u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .free_group(free_group), .free_slot(free_slot),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .alloc_group(alloc_group), .alloc_slot(alloc_slot),
    .groups_active(groups_active)
  );

  always #5 clk = ~clk;

  // Predicted allocator state.
  int slot_count_cfg;
  int nxt_slot[NG][NS];
  bit held[NG][NS];
  int top_slot[NG];
  int free_cnt[NG];
  int grp_size[NG];
  int grp_next[NG];
  int grp_prev[NG];
  bit on_list[NG];
  int head_grp, tail_grp, spare_grp, live_groups;

  request_t pending_reqs[$];
  grant_t expected_grants[$];
  int errors = 0;
  int grants_seen = 0;
  int alloc_fails = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int idle_cycles = 0;

  function automatic int clamped_size();
    if (slot_count_cfg < 1) return 1;
    if (slot_count_cfg > NS) return NS;
    return slot_count_cfg;
  endfunction

  function automatic void open_group(int g, int n);
    for (int s = 0; s < NS; s++) begin
      nxt_slot[g][s] = (s + 1 < n) ? s + 1 : NIL;
      held[g][s] = 0;
    end
    top_slot[g] = 0;
    free_cnt[g] = n;
    grp_size[g] = n;
  endfunction

  function automatic void list_append(int g);
    grp_prev[g] = tail_grp;
    grp_next[g] = NIL;
    if (tail_grp != NIL) grp_next[tail_grp] = g;
    else head_grp = g;
    tail_grp = g;
    on_list[g] = 1;
  endfunction

  function automatic void list_remove(int g);
    int p;
    int n;
    p = grp_prev[g];
    n = grp_next[g];
    if (p != NIL) grp_next[p] = n; else head_grp = n;
    if (n != NIL) grp_prev[n] = p; else tail_grp = p;
    grp_prev[g] = NIL;
    grp_next[g] = NIL;
    on_list[g] = 0;
  endfunction

  function automatic void pool_reset();
    slot_count_cfg = 16;
    for (int g = 0; g < NG; g++) begin
      for (int s = 0; s < NS; s++) begin
        nxt_slot[g][s] = NIL;
        held[g][s] = 0;
      end
      top_slot[g] = NIL;
      free_cnt[g] = 0;
      grp_size[g] = 0;
      grp_prev[g] = NIL;
      on_list[g] = 0;
      grp_next[g] = (g + 1 < NG) ? g + 1 : NIL;
    end
    open_group(0, clamped_size());
    grp_next[0] = NIL;
    on_list[0] = 1;
    head_grp = 0;
    tail_grp = 0;
    spare_grp = 1;
    live_groups = 1;
  endfunction

  function automatic grant_t pool_step(request_t r);
    grant_t res;
    int g;
    int s;
    res = '0;
    if (r.kind == 1'(REQ_ALLOC)) begin
      if (head_grp == NIL && spare_grp != NIL) begin
        g = spare_grp;
        spare_grp = grp_next[g];
        open_group(g, clamped_size());
        list_append(g);
        live_groups++;
      end
      if (head_grp == NIL) begin
        res.failed = 1'b1;
      end else begin
        g = head_grp;
        s = top_slot[g];
        top_slot[g] = nxt_slot[g][s];
        nxt_slot[g][s] = NIL;
        held[g][s] = 1;
        free_cnt[g]--;
        if (free_cnt[g] == 0) list_remove(g);
        res.grp = GW'(g);
        res.slt = SW'(s);
      end
    end else begin
      g = r.grp;
      s = r.slt;
      if (grp_size[g] != 0 && s < grp_size[g] && held[g][s]) begin
        held[g][s] = 0;
        nxt_slot[g][s] = top_slot[g];
        top_slot[g] = s;
        free_cnt[g]++;
        if (free_cnt[g] >= grp_size[g]) begin
          if (on_list[g]) list_remove(g);
          grp_next[g] = spare_grp;
          spare_grp = g;
          top_slot[g] = NIL;
          free_cnt[g] = 0;
          grp_size[g] = 0;
          live_groups--;
        end else if (!on_list[g]) begin
          list_append(g);
        end
      end
    end
    res.active = (GW+1)'(live_groups);
    return res;
  endfunction

  // Shadow of handles held, used only to make frees that hit real slots.
  request_t owned_handles[$];

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d (result word %0d)",
             what, got, want, grants_seen);
    errors++;
  endtask

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        request_t r;
        r = pending_reqs.pop_front();
        expected_grants.push_back(pool_step(r));
        in_valid <= 1;
        req_type <= r.kind;
        free_group <= r.grp;
        free_slot <= r.slt;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Monitor and receiver stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        grants_seen++;
        if (expected_grants.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          grant_t w;
          w = expected_grants.pop_front();
          if (w.failed) alloc_fails++;
          if (status !== w.failed) report_mismatch("status", status, w.failed);
          if (alloc_group !== w.grp) report_mismatch("alloc_group", alloc_group, w.grp);
          if (alloc_slot !== w.slt) report_mismatch("alloc_slot", alloc_slot, w.slt);
          if (groups_active !== w.active)
            report_mismatch("groups_active", groups_active, w.active);
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d words outstanding", expected_grants.size());
      $display("FAIL two_level_slot_pool_allocator");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_grants.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_slot_count(int v);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= CFG_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    slot_count_cfg = v;
  endtask

  // Queue a request; the owned-handle shadow follows the predicted pool state
  // loosely, it only steers frees toward slots that are probably held.
  task automatic queue_alloc();
    request_t r;
    r = '0;
    r.kind = 1'(REQ_ALLOC);
    r.grp = GW'($urandom);
    r.slt = SW'($urandom);
    pending_reqs.push_back(r);
  endtask

  task automatic queue_free(int g, int s);
    request_t r;
    r.kind = 1'(REQ_FREE);
    r.grp = GW'(g);
    r.slt = SW'(s);
    pending_reqs.push_back(r);
  endtask

  // Random phase: runs of allocations and frees of held handles, with bad frees.
  task automatic random_phase(int n);
    int cnt;
    cnt = 0;
    while (cnt < n) begin
      int pick;
      pick = $urandom_range(99);
      wait_drained();
      owned_handles.delete();
      for (int g = 0; g < NG; g++)
        for (int s = 0; s < NS; s++)
          if (held[g][s]) begin
            request_t h;
            h.kind = 1'(REQ_FREE);
            h.grp = GW'(g);
            h.slt = SW'(s);
            owned_handles.push_back(h);
          end
      owned_handles.shuffle();
      for (int k = 0; k < 30 && cnt < n; k++) begin
        pick = $urandom_range(99);
        if (pick < 48) begin
          queue_alloc();
        end else if (pick < 90 && owned_handles.size() > 0) begin
          request_t h;
          h = owned_handles.pop_front();
          queue_free(h.grp, h.slt);
        end else begin
          queue_free($urandom_range(NG - 1), $urandom_range(NS - 1));
        end
        cnt++;
      end
    end
    wait_drained();
  endtask

  initial begin
    pool_reset();
    repeat (5) @(posedge clk);
    rst <= 0;

    // Directed: drain group 0, open a spare, bad frees and frees of held slots.
    for (int i = 0; i < 17; i++) queue_alloc();
    queue_free(0, 5);
    queue_free(0, 5);
    queue_free(15, 15);
    queue_free(1, 15);
    queue_alloc();
    queue_free(1, 0);
    wait_drained();

    write_slot_count(1);
    for (int i = 0; i < 20; i++) queue_alloc();
    queue_free(0, 0);
    wait_drained();
    random_phase(150);

    write_slot_count(0);
    random_phase(150);

    sender_idle_pct = 87;
    write_slot_count(16);
    random_phase(300);

    sender_idle_pct = 0;
    receiver_stall_pct = 87;
    write_slot_count(31);
    random_phase(300);

    sender_idle_pct = 8;
    receiver_stall_pct = 8;
    write_slot_count(3);
    random_phase(400);

    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    write_slot_count(7);
    random_phase(400);

    $display("checked %0d result words, %0d failed allocations, slot counts 0 to 31",
             grants_seen, alloc_fails);
    if (errors == 0) begin
      $display("PASS two_level_slot_pool_allocator");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL two_level_slot_pool_allocator");
    end
    $finish;
  end
endmodule
